[rtl/core/ttw_pkg.sv]
`default_nettype none

package ttw_pkg;

  // screen geometry
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  // field widths
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned ADDR_W = $clog2(CELLS);

  // configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic REG_TEXT_COLOR = 1'b0;  // word index of the color register
  localparam logic [7:0] TEXT_COLOR_RST = 8'h07;

  // character codes and fixed cell values
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_FILL,
    ST_READ
  } state_e;

  typedef struct packed {
    op_e              opcode;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_word;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } out_item_t;

  // linear cell address of a row and column
  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

[rtl/core/text_terminal_writer_unit.sv]
`default_nettype none

// channel   direction  handshake                   payload
// in        sink       in_valid_i / in_ready_o     in_item_i  (opcode, char, read row/col)
// out       source     out_valid_o / out_ready_i   out_item_o (cell word, cursor row/col)
// cfg       sink       psel/penable/pwrite/pready  text_color at word address 0
//
// after reset a clearing pass writes the reset cell into all 2000 screen
// cells, during which no transaction is taken on the input
// put character, newline and unused opcode finish in the idle state; read cell
// goes on through the read state, as the screen memory read is registered
// newline on the last row: a copy sweep moves rows 1 to 24 up one row, then a
// blank sweep fills the last row, one cell per cycle through the single read and single write port
// clear screen: a sweep over all cells, one cell written per cycle
// a finished result waits in the output register and one more in a pending
// slot, so the next transaction is accepted while the previous result stalls

module text_terminal_writer_unit
  import ttw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,

  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);

  // sequencer state and sweep counter
  state_e            state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;

  // cursor and configured color
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [7:0]        color_q;

  // copy pipeline for scrolling and read range flag
  logic              rd_pend_q, rd_pend_d;
  logic [ADDR_W-1:0] wr_addr_q, wr_addr_d;
  logic              rd_ok_q, rd_ok_d;

  // output register and pending slot
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              pend_valid_q, pend_valid_d;
  out_item_t         pend_q, pend_d;

  // screen memory ports
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata_q;
  logic [CELL_W-1:0] mem [CELLS];

  // step completion
  logic              done;
  logic [CELL_W-1:0] done_word;

  logic              in_fire, cfg_write, is_newline, at_last_row, read_ok;
  logic [COL_W-1:0]  col_inc;
  logic [CELL_W-1:0] blank_cell;

  assign in_ready_o  = (state_q == ST_IDLE) && !pend_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_newline  = (in_item_i.char_code == NEWLINE_CODE);
  assign at_last_row = (row_q >= LAST_ROW);
  assign col_inc     = col_q + COL_W'(1);
  assign blank_cell  = {color_q, SPACE_CODE};
  assign read_ok     = (in_item_i.read_row < ROW_W'(ROWS)) &&
                       (in_item_i.read_col < COL_W'(COLUMNS));

  // configuration port, pready always high
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_TEXT_COLOR) ? CFG_DW'(color_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= TEXT_COLOR_RST;
    end else if (cfg_write && (paddr[2] == REG_TEXT_COLOR)) begin
      color_q <= pwdata[7:0];
    end
  end

  // next state and sweep counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_INIT, ST_FILL: begin
        if (cnt_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_item_i.opcode)
            OP_PUT: begin
              if (is_newline && at_last_row) begin
                state_d = ST_SCROLL;
                cnt_d   = '0;
              end
            end
            OP_CLEAR: begin
              state_d = ST_FILL;
              cnt_d   = '0;
            end
            OP_READ: state_d = ST_READ;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCROLL: begin
        // last row start is where the blank sweep begins, counter carries on
        if (cnt_q == SCROLL_END) begin
          state_d = ST_FILL;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // memory access, cursor update and completion
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = blank_cell;
    mem_re    = 1'b0;
    mem_raddr = cnt_q;
    row_d     = row_q;
    col_d     = col_q;
    rd_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    rd_ok_d   = rd_ok_q;
    done      = 1'b0;
    done_word = '0;
    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = RESET_CELL;
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_item_i.opcode)
            OP_PUT: begin
              if (is_newline) begin
                col_d = '0;
                if (at_last_row) begin
                  row_d = LAST_ROW;   // result follows the scroll sweep
                end else begin
                  row_d = row_q + ROW_W'(1);
                  done  = 1'b1;
                end
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cell_addr(row_q, col_q);
                mem_wdata = {color_q, in_item_i.char_code};
                done      = 1'b1;
                if (col_inc >= COL_W'(COLUMNS)) begin
                  // wrap, and past the last cell back to the top
                  col_d = '0;
                  row_d = at_last_row ? '0 : row_q + ROW_W'(1);
                end else begin
                  col_d = col_inc;
                end
              end
            end
            OP_CLEAR: begin
              row_d = '0;
              col_d = '0;
            end
            OP_READ: begin
              mem_re    = read_ok;
              mem_raddr = cell_addr(in_item_i.read_row, in_item_i.read_col);
              rd_ok_d   = read_ok;
            end
            default: done = 1'b1;
          endcase
        end
      end
      ST_SCROLL: begin
        // read one row ahead, write it back in the following cycle
        if (cnt_q != SCROLL_END) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_q + ADDR_W'(COLUMNS);
          rd_pend_d = 1'b1;
          wr_addr_d = cnt_q;
        end
        if (rd_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q;
          mem_wdata = mem_rdata_q;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        done   = (cnt_q == LAST_CELL);
      end
      ST_READ: begin
        done      = 1'b1;
        done_word = rd_ok_q ? mem_rdata_q : '0;
      end
      default: ;
    endcase
  end

  // output register with one pending slot behind it
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pend_valid_q && !out_valid_d) begin
      out_valid_d  = 1'b1;
      out_d        = pend_q;
      pend_valid_d = 1'b0;
    end
    if (done) begin
      if (!out_valid_d) begin
        out_valid_d = 1'b1;
        out_d       = '{cell_word: done_word, cursor_row: row_d, cursor_col: col_d};
      end else begin
        pend_valid_d = 1'b1;
        pend_d       = '{cell_word: done_word, cursor_row: row_d, cursor_col: col_d};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      cnt_q        <= '0;
      row_q        <= '0;
      col_q        <= '0;
      rd_pend_q    <= 1'b0;
      rd_ok_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      row_q        <= row_d;
      col_q        <= col_d;
      rd_pend_q    <= rd_pend_d;
      rd_ok_q      <= rd_ok_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    wr_addr_q <= wr_addr_d;
    out_q     <= out_d;
    pend_q    <= pend_d;
  end

  // screen memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // a result only waits in the pending slot behind a held output
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("pending result without a held output result");

  // cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q < ROW_W'(ROWS)) && (col_q < COL_W'(COLUMNS)))
    else $error("cursor off the screen");

  // the copy pipeline has drained before the blank sweep takes the write port
  a_copy_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> !rd_pend_q)
    else $error("scroll copy still in flight during blank sweep");

  // a newline on the last row runs the scroll sweep next
  a_scroll_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_item_i.opcode == OP_PUT) && is_newline && at_last_row)
      |=> (state_q == ST_SCROLL) && (row_q == LAST_ROW) && (col_q == '0))
    else $error("scroll did not start on newline at last row");

endmodule

`default_nettype wire
